FILE: rtl/lzss_stream_decoder_top_defines.svh
// assertion helpers for the lzss stream decoder
`ifndef LZSS_STREAM_DECODER_TOP_DEFINES_SVH
`define LZSS_STREAM_DECODER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define LZSS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define LZSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// what must hold right after a reset cycle
`define LZSS_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lzss_pkg.sv
`timescale 1ns / 1ps
package lzss_pkg;

   localparam int RING_SIZE  = 4096;
   localparam int MAX_MATCH  = 18;
   localparam int MATCH_BIAS = 3;
   localparam int RING_AW    = $clog2(RING_SIZE);
   localparam int START_POS  = RING_SIZE - MAX_MATCH;
   localparam int FILL_W     = RING_AW + 1;
   localparam int COUNT_W    = $clog2(MAX_MATCH + 1);
   localparam int CMD_DEPTH  = 4;
   localparam int CMD_AW     = $clog2(CMD_DEPTH);

   localparam logic [7:0] SPACE_BYTE = 8'h20;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;
   localparam logic [7:0] FLAG_FILL  = 8'hff;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_LIT,
      PH_PAIR_LO,
      PH_PAIR_HI
   } phase_type;

   typedef enum logic [1:0] {
      CMD_LIT,
      CMD_COPY,
      CMD_END
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [7:0]           data;
      logic [RING_AW-1:0]   offset;
      logic [COUNT_W-1:0]   count;
      logic                 last;
   } cmd_type;

endpackage

FILE: rtl/lzss_stream_decoder_top.sv
// path: a literal goes through the command queue, then the rsp output register; a
// copy's bytes go through the queue, a registered ring read, then the rsp register
// throughput: up to one request per cycle while the four-entry command queue has room;
// copies alternate a ring read and a write-back per byte, and hold while rsp stalls
// reset (synchronous) and end of stream restart the parser and write position; a
// fill count makes unwritten ring positions read as space below the start, else zero
`timescale 1ns / 1ps
module lzss_stream_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);
   import lzss_pkg::*;

   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    cmd_push;
   logic    cmd_full;
   logic    head_valid;
   logic    cmd_pop;

   lzss_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_last_in (req_last_in),
      .cmd_full    (cmd_full),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd)
   );

   lzss_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (push_cmd),
      .full       (cmd_full),
      .pop        (cmd_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   lzss_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (head_valid),
      .cmd             (head_cmd),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

FILE: rtl/lzss_front.sv
`timescale 1ns / 1ps
module lzss_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_in_byte,
   input  logic              req_last_in,
   input  logic              cmd_full,
   output logic              cmd_push,
   output lzss_pkg::cmd_type cmd
);
   import lzss_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] flag_ff, flag_in;
   logic [7:0]  lo_ff, lo_in;
   logic [15:0] flag_shifted;
   logic        accept;

   assign req_stall    = cmd_full;
   assign accept       = req_valid && !cmd_full;
   assign flag_shifted = {1'b0, flag_ff[15:1]};

   always_comb begin
      phase_in = phase_ff;
      flag_in  = flag_ff;
      lo_in    = lo_ff;
      if (accept) begin
         case (phase_ff)
            PH_FLAG: begin
               flag_in  = {FLAG_FILL, req_in_byte};
               phase_in = req_in_byte[0] ? PH_LIT : PH_PAIR_LO;
            end
            PH_LIT, PH_PAIR_HI: begin
               // bit 8 drops out once all eight control bits are used
               flag_in = flag_shifted;
               if (!flag_shifted[8]) begin
                  phase_in = PH_FLAG;
               end else begin
                  phase_in = flag_shifted[0] ? PH_LIT : PH_PAIR_LO;
               end
            end
            PH_PAIR_LO: begin
               lo_in    = req_in_byte;
               phase_in = PH_PAIR_HI;
            end
            default: begin
               phase_in = PH_FLAG;
            end
         endcase
         if (req_last_in) begin
            phase_in = PH_FLAG;
            flag_in  = '0;
            lo_in    = '0;
         end
      end
   end

   always_comb begin
      cmd_push   = 1'b0;
      cmd.kind   = CMD_END;
      cmd.data   = req_in_byte;
      cmd.offset = {req_in_byte[7:4], lo_ff};
      cmd.count  = {1'b0, req_in_byte[3:0]} + COUNT_W'(MATCH_BIAS);
      cmd.last   = req_last_in;
      if (accept) begin
         case (phase_ff)
            PH_LIT: begin
               cmd_push = 1'b1;
               cmd.kind = CMD_LIT;
            end
            PH_PAIR_HI: begin
               cmd_push = 1'b1;
               cmd.kind = CMD_COPY;
            end
            PH_FLAG, PH_PAIR_LO: begin
               // nothing to emit, but the back end still has to restart
               cmd_push = req_last_in;
               cmd.kind = CMD_END;
            end
            default: begin
               cmd_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FLAG;
         flag_ff  <= '0;
         lo_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         flag_ff  <= flag_in;
         lo_ff    <= lo_in;
      end
   end

endmodule

FILE: rtl/lzss_cmd_fifo.sv
`timescale 1ns / 1ps
module lzss_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lzss_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output lzss_pkg::cmd_type head_cmd
);
   import lzss_pkg::*;

   cmd_type           slot_ff [CMD_DEPTH];
   logic [CMD_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_AW:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == (CMD_AW + 1)'(CMD_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/lzss_back.sv
`timescale 1ns / 1ps
module lzss_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  lzss_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last_of_run
);
   import lzss_pkg::*;

   localparam logic [RING_AW-1:0] START_ADDR = RING_AW'(START_POS);
   localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(RING_SIZE);

   back_state_type     state_ff, state_in;
   logic [RING_AW-1:0] wp_ff, wp_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [RING_AW-1:0] src_ff;
   logic [COUNT_W-1:0] remain_ff;
   logic               last_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff;
   logic               rsp_last_ff;

   logic [7:0]         ring_mem [RING_SIZE];
   logic [7:0]         rd_q_ff;
   logic               rd_hit_ff;
   logic [7:0]         rd_dflt_ff;
   logic [RING_AW-1:0] rd_dist;
   logic [7:0]         rd_byte;

   logic               out_free;
   logic               mem_we;
   logic [7:0]         mem_wdata;
   logic               load_out;
   logic [7:0]         out_data;
   logic               out_last;
   logic               reinit;
   logic               start_copy;
   logic               rd_en;
   logic               step;
   logic               last_byte;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_byte = (remain_ff == COUNT_W'(1));
   // positions written since the stream began form one run starting at the start position
   assign rd_dist   = src_ff - START_ADDR;
   assign rd_byte   = rd_hit_ff ? rd_q_ff : rd_dflt_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && cmd.kind == CMD_COPY) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free) begin
               state_in = last_byte ? BK_IDLE : BK_READ;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_pop    = 1'b0;
      mem_we     = 1'b0;
      mem_wdata  = cmd.data;
      load_out   = 1'b0;
      out_data   = cmd.data;
      out_last   = 1'b1;
      reinit     = 1'b0;
      start_copy = 1'b0;
      rd_en      = 1'b0;
      step       = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_LIT: begin
                     if (out_free) begin
                        cmd_pop  = 1'b1;
                        mem_we   = 1'b1;
                        load_out = 1'b1;
                        reinit   = cmd.last;
                     end
                  end
                  CMD_COPY: begin
                     cmd_pop    = 1'b1;
                     start_copy = 1'b1;
                  end
                  CMD_END: begin
                     cmd_pop = 1'b1;
                     reinit  = 1'b1;
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         BK_READ: begin
            rd_en = 1'b1;
         end
         BK_EMIT: begin
            if (out_free) begin
               mem_we    = 1'b1;
               mem_wdata = rd_byte;
               load_out  = 1'b1;
               out_data  = rd_byte;
               out_last  = last_byte;
               step      = 1'b1;
               reinit    = last_ff && last_byte;
            end
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (reinit) begin
         wp_in   = START_ADDR;
         fill_in = '0;
      end else if (mem_we) begin
         wp_in = wp_ff + 1'b1;
         if (fill_ff != FILL_FULL) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         wp_ff        <= START_ADDR;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start_copy) begin
         src_ff    <= cmd.offset;
         remain_ff <= cmd.count;
         last_ff   <= cmd.last;
      end else if (step) begin
         src_ff    <= src_ff + 1'b1;
         remain_ff <= remain_ff - 1'b1;
      end
      if (load_out) begin
         rsp_byte_ff <= out_data;
         rsp_last_ff <= out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wp_ff] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff    <= ring_mem[src_ff];
         rd_hit_ff  <= ({1'b0, rd_dist} < fill_ff);
         rd_dflt_ff <= (src_ff < START_ADDR) ? SPACE_BYTE : ZERO_BYTE;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

FILE: rtl/lzss_checker.sv
`timescale 1ns / 1ps
`include "lzss_stream_decoder_top_defines.svh"
module lzss_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       req_last_in,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   `LZSS_ASSERT_NEXT(a_rsp_valid_holds, rsp_valid && rsp_stall, rsp_valid, "rsp valid dropped while stalled")
   `LZSS_ASSERT_NEXT(a_rsp_payload_holds, rsp_valid && rsp_stall, $stable(rsp_out_byte) && $stable(rsp_last_of_run), "rsp payload changed while stalled")
   `LZSS_ASSERT_RESET(a_rsp_idle_after_reset, !rsp_valid && !req_stall, "response or stall right after reset")
   // the queue only fills up on the cycle after a request was taken
   `LZSS_ASSERT_NOW(a_stall_needs_request, $rose(req_stall), $past(req_valid && !req_stall), "req stall rose without a request")

endmodule

bind lzss_stream_decoder_top lzss_checker u_checker (.*);
